FILE: sv/hvd_pkg.sv
package hvd_pkg;

  localparam int CORDIC_STAGES = 30;
  localparam int SQRT_STAGES   = 31;
  localparam int SC_LAT        = 34;
  localparam int SQRT_LAT      = 32;
  localparam int PIPE_LAT      = 105;

  typedef logic signed [31:0] ang_t;
  typedef logic signed [32:0] diff_t;
  typedef logic signed [31:0] unit_t;
  typedef logic signed [33:0] cw_t;
  typedef logic signed [34:0] ext_t;

  localparam cw_t  ONE_Q30      = 34'sd1073741824;
  localparam cw_t  PI_Q30       = 34'sd3373259426;
  localparam cw_t  HALF_PI_Q30  = 34'sd1686629713;
  localparam ext_t TWO_PI_Q30   = 35'sd6746518852;
  localparam cw_t  GAIN_INV_Q30 = 34'sd652032874;
  localparam logic [29:0] PI_OUT = 30'd843314857;
  localparam logic [60:0] ONE_Q60 = 61'h1000_0000_0000_0000;

  localparam logic IDX_REF_LON = 1'b0;
  localparam logic IDX_REF_LAT = 1'b1;

  localparam cw_t ATAN_Q30 [CORDIC_STAGES] = '{
    34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
    34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
    34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536,
    34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
    34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64,
    34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
  };

  function automatic unit_t clamp_unit(input ext_t v);
    unit_t r;
    if (v > ext_t'(ONE_Q30)) begin
      r = 32'sd1073741824;
    end else if (v < -ext_t'(ONE_Q30)) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

FILE: sv/haversine_distance.sv
// One point per cycle sustained while the output is not stalled.
// Depth is set by the 30-stage sin/cos CORDIC, the 31-step square root and the
// 30-stage atan2 CORDIC, plus reduction, multiply and rounding stages.
// A stall at the output freezes the whole pipeline; nothing is lost or repeated.
// Synchronous active-low reset clears the valid pipeline and the reference registers.
module haversine_distance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // point_lon [31:0], point_lat [63:32]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // angular_distance [29:0], zero pad [31:30]
  output logic        out_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import hvd_pkg::*;

  logic en;
  logic [PIPE_LAT-1:0] vld_r;
  logic [PIPE_LAT-1:0] lst_r;
  ang_t ref_lon_r;
  ang_t ref_lat_r;
  ang_t pt_lon;
  ang_t pt_lat;
  diff_t dlat_r, dlon_r, lat_r, rlat_r;
  unit_t s1, s2, c2, cref, tmp0, tmp1, tmp2, tmp3;
  logic signed [63:0] pcc_r, ps1_r, ps1b_r, ps1c_r, ps1d_r, ps1e_r;
  logic signed [63:0] pt_r, pa_r, rnd_cc, rnd_t, asum;
  unit_t s2a_r, s2b_r, s2c_r, s2d_r, cc30_r, t30_r;
  logic [60:0] a_r;
  logic [60:0] b_val;
  logic [30:0] ra, rb;
  cw_t  ax_r [CORDIC_STAGES];
  cw_t  ay_r [CORDIC_STAGES];
  cw_t  az_r [CORDIC_STAGES];
  cw_t  zc;
  logic [31:0] d_r;
  logic [30:0] dq;
  logic [29:0] dist_r;

  assign en        = !vld_r[PIPE_LAT-1] || out_tready;
  assign in_tready = en;
  assign pready    = 1'b1;
  assign pt_lon    = in_tdata[31:0];
  assign pt_lat    = in_tdata[63:32];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_lon_r <= '0;
      ref_lat_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        IDX_REF_LON: ref_lon_r <= pwdata;
        IDX_REF_LAT: ref_lat_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      IDX_REF_LON: prdata = ref_lon_r;
      IDX_REF_LAT: prdata = ref_lat_r;
      default:     prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[PIPE_LAT-2:0], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lst_r  <= {lst_r[PIPE_LAT-2:0], in_tlast};
      dlat_r <= 33'(pt_lat) - 33'(ref_lat_r);
      dlon_r <= 33'(pt_lon) - 33'(ref_lon_r);
      lat_r  <= 33'(pt_lat);
      rlat_r <= 33'(ref_lat_r);
    end
  end

  hvd_sincos #(.HALF(1'b1)) u_sc_dlat (.clk, .en, .ang_i(dlat_r), .sin_o(s1),   .cos_o(tmp0));
  hvd_sincos #(.HALF(1'b1)) u_sc_dlon (.clk, .en, .ang_i(dlon_r), .sin_o(s2),   .cos_o(tmp1));
  hvd_sincos #(.HALF(1'b0)) u_sc_lat  (.clk, .en, .ang_i(lat_r),  .sin_o(tmp2), .cos_o(c2));
  hvd_sincos #(.HALF(1'b0)) u_sc_rlat (.clk, .en, .ang_i(rlat_r), .sin_o(tmp3), .cos_o(cref));

  assign rnd_cc = pcc_r + 64'sd536870912;
  assign rnd_t  = pt_r + 64'sd536870912;
  assign asum   = ps1e_r + pa_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pcc_r  <= cref * c2;
      ps1_r  <= s1 * s1;
      s2a_r  <= s2;
      cc30_r <= 32'(rnd_cc >>> 30);
      ps1b_r <= ps1_r;
      s2b_r  <= s2a_r;
      pt_r   <= cc30_r * s2b_r;
      ps1c_r <= ps1b_r;
      s2c_r  <= s2b_r;
      t30_r  <= 32'(rnd_t >>> 30);
      ps1d_r <= ps1c_r;
      s2d_r  <= s2c_r;
      pa_r   <= t30_r * s2d_r;
      ps1e_r <= ps1d_r;
      if (asum < 0) begin
        a_r <= '0;
      end else if (asum > 64'(ONE_Q60)) begin
        a_r <= ONE_Q60;
      end else begin
        a_r <= asum[60:0];
      end
    end
  end

  assign b_val = ONE_Q60 - a_r;

  hvd_isqrt u_sqrt_a (.clk, .en, .v_i(a_r),   .root_o(ra));
  hvd_isqrt u_sqrt_b (.clk, .en, .v_i(b_val), .root_o(rb));

  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_vec
    cw_t xi, yi, zi;
    if (gi == 0) begin : g_src0
      assign xi = {3'b000, rb};
      assign yi = {3'b000, ra};
      assign zi = '0;
    end else begin : g_srcn
      assign xi = ax_r[gi-1];
      assign yi = ay_r[gi-1];
      assign zi = az_r[gi-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (yi > 0) begin
          ax_r[gi] <= xi + (yi >>> gi);
          ay_r[gi] <= yi - (xi >>> gi);
          az_r[gi] <= zi + ATAN_Q30[gi];
        end else if (yi < 0) begin
          ax_r[gi] <= xi - (yi >>> gi);
          ay_r[gi] <= yi + (xi >>> gi);
          az_r[gi] <= zi - ATAN_Q30[gi];
        end else begin
          ax_r[gi] <= xi;
          ay_r[gi] <= yi;
          az_r[gi] <= zi;
        end
      end
    end
  end

  always_comb begin
    priority if (az_r[CORDIC_STAGES-1] < 0) begin
      zc = '0;
    end else if (az_r[CORDIC_STAGES-1] > HALF_PI_Q30) begin
      zc = HALF_PI_Q30;
    end else begin
      zc = az_r[CORDIC_STAGES-1];
    end
  end

  assign dq = 31'((33'(d_r) + 33'd2) >> 2);

  always_ff @(posedge clk) begin
    if (en) begin
      d_r    <= {zc[30:0], 1'b0};
      dist_r <= (dq > 31'(PI_OUT)) ? PI_OUT : dq[29:0];
    end
  end

  assign out_tvalid = vld_r[PIPE_LAT-1];
  assign out_tlast  = lst_r[PIPE_LAT-1];
  assign out_tdata  = {2'b00, dist_r};

endmodule

FILE: sv/hvd_sincos.sv
module hvd_sincos #(
  parameter bit HALF = 1'b0
) (
  input  logic           clk,
  input  logic           en,
  input  hvd_pkg::diff_t ang_i,
  output hvd_pkg::unit_t sin_o,
  output hvd_pkg::unit_t cos_o
);
  import hvd_pkg::*;

  localparam logic signed [35:0] MOD_N = HALF ? 36'sd3373259426 : 36'sd1686629713;

  logic signed [35:0] ax;
  logic signed [35:0] rm;
  ext_t r30_nxt;
  ext_t r30_r;
  ext_t zr_r;
  cw_t  z0;
  logic fl0;
  cw_t  xs_r [CORDIC_STAGES+1];
  cw_t  ys_r [CORDIC_STAGES+1];
  cw_t  zs_r [CORDIC_STAGES+1];
  logic fl_r [CORDIC_STAGES+1];
  unit_t sin_r;
  unit_t cos_r;

  always_comb begin
    ax = 36'(ang_i);
    if (ax < 0) begin
      rm = (ax + MOD_N >= 0) ? ax + MOD_N : ax + 2 * MOD_N;
    end else begin
      rm = (ax >= MOD_N) ? ax - MOD_N : ax;
    end
    r30_nxt = HALF ? 35'(rm <<< 1) : 35'(rm <<< 2);
  end

  always_comb begin
    if (zr_r > ext_t'(HALF_PI_Q30)) begin
      z0  = 34'(ext_t'(PI_Q30) - zr_r);
      fl0 = 1'b1;
    end else if (zr_r < -ext_t'(HALF_PI_Q30)) begin
      z0  = 34'(-ext_t'(PI_Q30) - zr_r);
      fl0 = 1'b1;
    end else begin
      z0  = 34'(zr_r);
      fl0 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r30_r   <= r30_nxt;
      zr_r    <= (r30_r > ext_t'(PI_Q30)) ? r30_r - TWO_PI_Q30 : r30_r;
      xs_r[0] <= GAIN_INV_Q30;
      ys_r[0] <= '0;
      zs_r[0] <= z0;
      fl_r[0] <= fl0;
    end
  end

  for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_rot
    always_ff @(posedge clk) begin
      if (en) begin
        fl_r[gi+1] <= fl_r[gi];
        if (zs_r[gi] >= 0) begin
          xs_r[gi+1] <= xs_r[gi] - (ys_r[gi] >>> gi);
          ys_r[gi+1] <= ys_r[gi] + (xs_r[gi] >>> gi);
          zs_r[gi+1] <= zs_r[gi] - ATAN_Q30[gi];
        end else begin
          xs_r[gi+1] <= xs_r[gi] + (ys_r[gi] >>> gi);
          ys_r[gi+1] <= ys_r[gi] - (xs_r[gi] >>> gi);
          zs_r[gi+1] <= zs_r[gi] + ATAN_Q30[gi];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_r <= clamp_unit(35'(ys_r[CORDIC_STAGES]));
      cos_r <= clamp_unit(fl_r[CORDIC_STAGES] ? -35'(xs_r[CORDIC_STAGES])
                                              : 35'(xs_r[CORDIC_STAGES]));
    end
  end

  assign sin_o = sin_r;
  assign cos_o = cos_r;

endmodule

FILE: sv/hvd_isqrt.sv
module hvd_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] v_i,
  output logic [30:0] root_o
);
  import hvd_pkg::*;

  logic [60:0] vs_r [SQRT_STAGES+1];
  logic [61:0] rs_r [SQRT_STAGES+1];

  always_ff @(posedge clk) begin
    if (en) begin
      vs_r[0] <= v_i;
      rs_r[0] <= '0;
    end
  end

  for (genvar gk = 0; gk < SQRT_STAGES; gk++) begin : g_dig
    localparam logic [61:0] BIT = 62'(1) << (60 - 2 * gk);
    logic [61:0] trial;
    assign trial = rs_r[gk] + BIT;
    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, vs_r[gk]} >= trial) begin
          vs_r[gk+1] <= vs_r[gk] - trial[60:0];
          rs_r[gk+1] <= (rs_r[gk] >> 1) + BIT;
        end else begin
          vs_r[gk+1] <= vs_r[gk];
          rs_r[gk+1] <= rs_r[gk] >> 1;
        end
      end
    end
  end

  assign root_o = rs_r[SQRT_STAGES][30:0];

endmodule

FILE: sv/hvd_checker.sv
module hvd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [63:0] in_tdata,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);
  import hvd_pkg::*;

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[29:0] <= PI_OUT) && (out_tdata[31:30] == 2'b00))
    else $error("distance out of range");

  a_free_in: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");

  a_take_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input blocked while output drains");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("stalled result changed");

  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    psel |-> pready)
    else $error("config port not ready");

endmodule

bind haversine_distance hvd_checker u_hvd_checker (.*);
